// ===== rtl/core/jump_range_set_match_macros.svh =====
// Assertion macros shared by the jump range table RTL.
// Expects clk and arst_n in the scope of every use.
`ifndef JUMP_RANGE_SET_MATCH_MACROS_SVH
`define JUMP_RANGE_SET_MATCH_MACROS_SVH

// same-cycle implication
`define JRSM_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define JRSM_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/jrsm_pkg.sv =====
// Types and constants for the jump range table.
// No dependencies.
`default_nettype none

package jrsm_pkg;

	localparam int FIELD_W = 32;
	localparam int OP_W    = 2;
	localparam int COUNT_W = 5;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR    = 2'd0,
		OP_ADD      = 2'd1,
		OP_ADD_CMPL = 2'd2,
		OP_QUERY    = 2'd3
	} op_t;

	// controller -> datapath
	typedef struct packed {
		logic start;      // input transaction accepted this cycle
		logic wr2;        // write second complement piece
		logic scan_issue; // read next table entry
		logic load_out;   // load result register
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_query;
		logic need_wr2;
		logic scan_more;
		logic match_now;
		logic cmp_pending;
	} dp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/jrsm_in_if.sv =====
// Input channel of the jump range table: valid/ready plus one command.
// Depends on jrsm_pkg.
`default_nettype none

interface jrsm_in_if;
	logic                          valid;
	logic                          ready;
	logic [jrsm_pkg::OP_W-1:0]     op;
	logic [jrsm_pkg::FIELD_W-1:0]  range_low;
	logic [jrsm_pkg::FIELD_W-1:0]  range_high;
	logic [jrsm_pkg::FIELD_W-1:0]  data_size;
	logic [jrsm_pkg::FIELD_W-1:0]  last_pos;
	logic [jrsm_pkg::FIELD_W-1:0]  new_pos;

	modport source (output valid, op, range_low, range_high, data_size, last_pos, new_pos,
		input ready);
	modport sink (input valid, op, range_low, range_high, data_size, last_pos, new_pos,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/core/jrsm_out_if.sv =====
// Result channel of the jump range table: valid/ready plus one result.
// Depends on jrsm_pkg.
`default_nettype none

interface jrsm_out_if;
	logic                          valid;
	logic                          ready;
	logic                          hit;
	logic [jrsm_pkg::COUNT_W-1:0]  range_count;
	logic                          overflow;

	modport source (output valid, hit, range_count, overflow, input ready);
	modport sink (input valid, hit, range_count, overflow, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/jrsm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module jrsm_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/jrsm_datapath.sv =====
// Datapath of the jump range table: range RAM, entry count, complement
// splitting, scan comparator and result register. Depends on jrsm_pkg, jrsm_ram.
`default_nettype none

module jrsm_datapath #(
	parameter int MAX_RANGES = 16,
	parameter int POS_WIDTH  = 32
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire jrsm_pkg::dp_cmd_t               cmd,
	output jrsm_pkg::dp_sts_t                    sts,
	input  wire logic [jrsm_pkg::OP_W-1:0]       op,
	input  wire logic [jrsm_pkg::FIELD_W-1:0]    range_low,
	input  wire logic [jrsm_pkg::FIELD_W-1:0]    range_high,
	input  wire logic [jrsm_pkg::FIELD_W-1:0]    data_size,
	input  wire logic [jrsm_pkg::FIELD_W-1:0]    last_pos,
	input  wire logic [jrsm_pkg::FIELD_W-1:0]    new_pos,
	output logic                                 hit,
	output logic      [jrsm_pkg::COUNT_W-1:0]    range_count,
	output logic                                 overflow
);
	import jrsm_pkg::*;
	`include "jump_range_set_match_macros.svh"

	localparam int W  = (POS_WIDTH < FIELD_W) ? POS_WIDTH : FIELD_W;
	localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
	localparam int CW = $clog2(MAX_RANGES + 1);

	op_t          op_e;
	logic [W-1:0] lo_w, hi_w, size_w, last_w, pos_w;
	logic [W:0]   hi_inc;
	logic         below, above, is_add, ovf_now;
	logic [1:0]   need;
	logic [CW:0]  sum;
	logic [W-1:0] p0_lo, p0_hi;
	logic         we_first, ram_we;
	logic [2*W-1:0] wdata, rdata;
	logic [W-1:0] rd_lo, rd_hi;
	logic         match;

	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [W-1:0]  pend_lo_q, pend_hi_q;
	logic [W-1:0]  dist_q;
	logic          neg_q;
	logic          ovf_q;
	logic          hit_q;
	logic          cmp_v_s1;
	logic          res_hit_q, res_ovf_q;
	logic [COUNT_W-1:0] res_cnt_q;

	assign op_e   = op_t'(op);
	assign lo_w   = range_low[W-1:0];
	assign hi_w   = range_high[W-1:0];
	assign size_w = data_size[W-1:0];
	assign last_w = last_pos[W-1:0];
	assign pos_w  = new_pos[W-1:0];

	// complement pieces: [0, lo-1] and [hi+1, size-1]
	assign hi_inc = {1'b0, hi_w} + (W+1)'(1);
	assign below  = (lo_w != '0);
	assign above  = (hi_inc < {1'b0, size_w});
	assign is_add = op_e inside {OP_ADD, OP_ADD_CMPL};
	assign need   = (op_e == OP_ADD) ? 2'd1 : ({1'b0, below} + {1'b0, above});
	assign sum    = {1'b0, count_q} + (CW+1)'(need);
	assign ovf_now = is_add && (sum > (CW+1)'(MAX_RANGES));

	always_comb begin
		if (op_e == OP_ADD) begin
			p0_lo = lo_w;
			p0_hi = hi_w;
		end else if (below) begin
			p0_lo = '0;
			p0_hi = lo_w - W'(1);
		end else begin
			p0_lo = hi_inc[W-1:0];
			p0_hi = size_w - W'(1);
		end
	end

	assign we_first = cmd.start && is_add && !ovf_now && ((op_e == OP_ADD) || below || above);
	assign ram_we   = we_first || cmd.wr2;
	assign wdata    = cmd.wr2 ? {pend_lo_q, pend_hi_q} : {p0_lo, p0_hi};

	jrsm_ram #(
		.WIDTH (2*W),
		.DEPTH (MAX_RANGES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[AW-1:0]),
		.wdata (wdata),
		.re    (cmd.scan_issue),
		.raddr (idx_q[AW-1:0]),
		.rdata (rdata)
	);

	// last + low <= pos <= last + high, rewritten against pos - last
	assign rd_lo = rdata[2*W-1:W];
	assign rd_hi = rdata[W-1:0];
	assign match = !neg_q && (rd_lo <= dist_q) && (dist_q <= rd_hi);

	assign sts.is_query    = (op_e == OP_QUERY);
	assign sts.need_wr2    = (op_e == OP_ADD_CMPL) && below && above && !ovf_now;
	assign sts.scan_more   = (idx_q < count_q);
	assign sts.match_now   = cmp_v_s1 && match;
	assign sts.cmp_pending = cmp_v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			idx_q    <= '0;
			cmp_v_s1 <= 1'b0;
			hit_q    <= 1'b0;
			ovf_q    <= 1'b0;
		end else begin
			if (cmd.start && (op_e == OP_CLEAR)) begin
				count_q <= '0;
			end else if (ram_we) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.start) begin
				idx_q    <= '0;
				cmp_v_s1 <= 1'b0;
				hit_q    <= 1'b0;
				ovf_q    <= ovf_now;
			end else begin
				if (cmd.scan_issue) begin
					idx_q <= idx_q + CW'(1);
				end
				cmp_v_s1 <= cmd.scan_issue;
				if (cmp_v_s1 && match) begin
					hit_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			pend_lo_q <= hi_inc[W-1:0];
			pend_hi_q <= size_w - W'(1);
			dist_q    <= pos_w - last_w;
			neg_q     <= (pos_w < last_w);
		end
		if (cmd.load_out) begin
			res_hit_q <= hit_q;
			res_cnt_q <= COUNT_W'(count_q);
			res_ovf_q <= ovf_q;
		end
	end

	assign hit         = res_hit_q;
	assign range_count = res_cnt_q;
	assign overflow    = res_ovf_q;

	`JRSM_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CW'(MAX_RANGES), "entry count above capacity")
	`JRSM_ASSERT_IMP(a_write_room, ram_we, count_q < CW'(MAX_RANGES), "table write while full")
	`JRSM_ASSERT_IMP(a_scan_in_range, cmd.scan_issue, idx_q < count_q, "scan read past last entry")
	`JRSM_ASSERT_NXT(a_ovf_keeps_table, cmd.start && ovf_now, count_q == $past(count_q),
		"dropped add changed the table")

endmodule

`default_nettype wire

// ===== rtl/core/jrsm_ctrl.sv =====
// Controller of the jump range table: sequences adds, the query scan and the
// result handoff. Depends on jrsm_pkg.
`default_nettype none

module jrsm_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	output logic                     out_valid,
	input  wire logic                out_ready,
	input  wire jrsm_pkg::dp_sts_t   sts,
	output jrsm_pkg::dp_cmd_t        cmd
);
	import jrsm_pkg::*;
	`include "jump_range_set_match_macros.svh"

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WR2,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   scan_end;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	assign scan_end = sts.match_now || (!sts.scan_more && !sts.cmp_pending);

	assign cmd.start      = in_valid && in_ready;
	assign cmd.wr2        = (state_q == ST_WR2);
	assign cmd.scan_issue = (state_q == ST_SCAN) && sts.scan_more && !sts.match_now;
	assign cmd.load_out   = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						if (sts.is_query) begin
							state_q <= ST_SCAN;
						end else if (sts.need_wr2) begin
							state_q <= ST_WR2;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_WR2: begin
					state_q <= ST_DONE;
				end
				ST_SCAN: begin
					if (scan_end) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (cmd.load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`JRSM_ASSERT_NXT(a_wr2_once, state_q == ST_WR2, state_q == ST_DONE, "second write not single")
	`JRSM_ASSERT_NXT(a_start_leaves_idle, cmd.start, state_q != ST_IDLE, "accept did not start work")
	`JRSM_ASSERT_NXT(a_load_hands_off, cmd.load_out, (state_q == ST_IDLE) && out_valid_q,
		"result load did not present a result")

endmodule

`default_nettype wire

// ===== rtl/core/jump_range_set_match.sv =====
// Jump range table for a pattern scanner.
// Channels: req (sink) carries one command per transaction: clear, add range,
// add complement of a range within data_size, or query new_pos against the
// stored ranges measured from last_pos. rsp (source) returns one result per
// command: hit, range_count and overflow.
// After req is accepted, clears, single adds, dropped adds and empty or
// one-piece complements go straight to the result load; a complement that
// adds two ranges first writes its second piece, and a query first scans
// the ranges held (at most MAX_RANGES).
// The query time is set by the scan, which reads one entry per cycle from the
// range RAM through one comparator and stops at the first hit.
// One command is worked at a time; req is ready again the cycle after the
// result is loaded into the rsp register, and the next command can start
// while that result still waits.
// Reset empties the table (count to zero); RAM contents are never read below
// a write. If rsp is stalled, a finished command waits before the result
// register and req stays not ready until the held result is taken.
// Depends on jrsm_pkg, jrsm_in_if, jrsm_out_if, jrsm_ctrl, jrsm_datapath.
`default_nettype none

module jump_range_set_match #(
	parameter int MAX_RANGES = 16,
	parameter int POS_WIDTH  = 32
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	jrsm_in_if.sink    req,
	jrsm_out_if.source rsp
);
	import jrsm_pkg::*;

	dp_cmd_t dp_cmd;
	dp_sts_t dp_sts;

	jrsm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (dp_sts),
		.cmd       (dp_cmd)
	);

	jrsm_datapath #(
		.MAX_RANGES (MAX_RANGES),
		.POS_WIDTH  (POS_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (dp_cmd),
		.sts         (dp_sts),
		.op          (req.op),
		.range_low   (req.range_low),
		.range_high  (req.range_high),
		.data_size   (req.data_size),
		.last_pos    (req.last_pos),
		.new_pos     (req.new_pos),
		.hit         (rsp.hit),
		.range_count (rsp.range_count),
		.overflow    (rsp.overflow)
	);

endmodule

`default_nettype wire
